// ===== design/bra_pkg.sv =====
// Shared types, constants and datapath command codes for the rational approximation block.
package bra_pkg;

	localparam int VALUE_WIDTH = 50;
	localparam int DEN_WIDTH   = 32;
	localparam int DW          = 64;
	localparam int PW          = 2 * DW;
	localparam int CNT_W       = $clog2(DW + 1);

	localparam logic [DW-1:0]        SCALE      = 64'd1000000000000;
	localparam logic [DEN_WIDTH-1:0] MAXD_RESET = 32'd1000000;

	typedef struct packed {
		logic                   negative;
		logic [VALUE_WIDTH-1:0] value_magnitude;
	} bra_in_t;

	typedef struct packed {
		logic                   result_negative;
		logic [VALUE_WIDTH-1:0] numerator;
		logic [DEN_WIDTH-1:0]   denominator;
	} bra_out_t;

	typedef logic [5:0] bra_cmd_t;

	localparam bra_cmd_t C_NOP      = 6'd0;
	localparam bra_cmd_t C_LOAD     = 6'd1;
	localparam bra_cmd_t C_GCD_DIV  = 6'd2;
	localparam bra_cmd_t C_GCD_UPD  = 6'd3;
	localparam bra_cmd_t C_RED1_DIV = 6'd4;
	localparam bra_cmd_t C_RED1_UPD = 6'd5;
	localparam bra_cmd_t C_RED2_DIV = 6'd6;
	localparam bra_cmd_t C_RED2_UPD = 6'd7;
	localparam bra_cmd_t C_EXACT    = 6'd8;
	localparam bra_cmd_t C_CF_INIT  = 6'd9;
	localparam bra_cmd_t C_CF_DIV   = 6'd10;
	localparam bra_cmd_t C_CF_AUPD  = 6'd11;
	localparam bra_cmd_t C_T_DIV    = 6'd12;
	localparam bra_cmd_t C_M1_MUL   = 6'd13;
	localparam bra_cmd_t C_M1_UPD   = 6'd14;
	localparam bra_cmd_t C_M2_MUL   = 6'd15;
	localparam bra_cmd_t C_M2_UPD   = 6'd16;
	localparam bra_cmd_t C_K_FIX    = 6'd17;
	localparam bra_cmd_t C_K_DIV    = 6'd18;
	localparam bra_cmd_t C_K_UPD    = 6'd19;
	localparam bra_cmd_t C_BN_MUL   = 6'd20;
	localparam bra_cmd_t C_BN_UPD   = 6'd21;
	localparam bra_cmd_t C_BD_MUL   = 6'd22;
	localparam bra_cmd_t C_BD_UPD   = 6'd23;
	localparam bra_cmd_t C_X1_MUL   = 6'd24;
	localparam bra_cmd_t C_X_UPD    = 6'd25;
	localparam bra_cmd_t C_Y1_MUL   = 6'd26;
	localparam bra_cmd_t C_G_UPD    = 6'd27;
	localparam bra_cmd_t C_C1_MUL   = 6'd28;
	localparam bra_cmd_t C_C1_UPD   = 6'd29;
	localparam bra_cmd_t C_X2_MUL   = 6'd30;
	localparam bra_cmd_t C_Y2_MUL   = 6'd31;
	localparam bra_cmd_t C_C2_MUL   = 6'd32;
	localparam bra_cmd_t C_PICK     = 6'd33;
	localparam bra_cmd_t C_OUT      = 6'd34;

	typedef struct packed {
		logic div_done;
		logic mul_done;
		logic gb_zero;
		logic d_zero;
		logic q1_zero;
		logic exact;
		logic a_over;
		logic q2_over;
		logic out_free;
	} bra_stat_t;

endpackage

// ===== design/bra_datapath.sv =====
// Datapath: working registers, shared serial divider and shift-add multiplier, result register.
module bra_datapath import bra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bra_cmd_t             cmd,
	input  bra_in_t              in_data,
	input  logic                 cfg_wen,
	input  logic [DEN_WIDTH-1:0] cfg_wdata,
	input  logic                 out_ready,
	output logic                 out_valid,
	output bra_out_t             out_data,
	output bra_stat_t            stat
);

	logic [DEN_WIDTH-1:0] maxd_q;
	logic [DW-1:0] lim_q, n0_q, d0_q, ga_q, gb_q;
	logic [DW-1:0] n_q, d_q, r_q, a_q, p0_q, q0_q, p1_q, q1_q, q2_q, k_q, bn_q, bd_q;
	logic [DW-1:0] res_n_q, res_d_q;
	logic [PW-1:0] x_q, g_q, c1_q;
	logic          neg_q, out_valid_q;
	bra_out_t      out_q;

	logic             div_run_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [DW-1:0]    div_r_q, div_q_q, div_d_q;
	logic             div_start, div_done;
	logic [DW-1:0]    div_na, div_nb;
	logic [DW:0]      div_sh, div_sub;
	logic             div_ge;

	logic          mul_run_q;
	logic [PW-1:0] mul_a_q, mul_p_q;
	logic [DW-1:0] mul_b_q;
	logic          mul_start, mul_done;
	logic [PW-1:0] mul_na;
	logic [DW-1:0] mul_nb;

	logic [DW-1:0] q2_sum;

	// divider operand select
	always_comb begin
		div_start = 1'b1;
		div_na    = '0;
		div_nb    = '0;
		case (cmd)
			C_GCD_DIV: begin
				div_na = ga_q;
				div_nb = gb_q;
			end
			C_RED1_DIV: begin
				div_na = n0_q;
				div_nb = ga_q;
			end
			C_RED2_DIV: begin
				div_na = SCALE;
				div_nb = ga_q;
			end
			C_CF_DIV: begin
				div_na = n_q;
				div_nb = d_q;
			end
			C_T_DIV, C_K_DIV: begin
				div_na = lim_q - q0_q;
				div_nb = q1_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// multiplier operand select
	always_comb begin
		mul_start = 1'b1;
		mul_na    = '0;
		mul_nb    = '0;
		case (cmd)
			C_M1_MUL: begin
				mul_na = PW'(a_q);
				mul_nb = q1_q;
			end
			C_M2_MUL: begin
				mul_na = PW'(a_q);
				mul_nb = p1_q;
			end
			C_BN_MUL: begin
				mul_na = PW'(k_q);
				mul_nb = p1_q;
			end
			C_BD_MUL: begin
				mul_na = PW'(k_q);
				mul_nb = q1_q;
			end
			C_X1_MUL: begin
				mul_na = PW'(p1_q);
				mul_nb = d0_q;
			end
			C_Y1_MUL: begin
				mul_na = PW'(n0_q);
				mul_nb = q1_q;
			end
			C_C1_MUL: begin
				mul_na = g_q;
				mul_nb = bd_q;
			end
			C_X2_MUL: begin
				mul_na = PW'(bn_q);
				mul_nb = d0_q;
			end
			C_Y2_MUL: begin
				mul_na = PW'(n0_q);
				mul_nb = bd_q;
			end
			C_C2_MUL: begin
				mul_na = g_q;
				mul_nb = q1_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign div_done = div_run_q && (div_cnt_q == '0);
	assign div_sh   = {div_r_q, div_q_q[DW-1]};
	assign div_ge   = div_sh >= {1'b0, div_d_q};
	assign div_sub  = div_sh - {1'b0, div_d_q};
	assign mul_done = mul_run_q && (mul_b_q == '0);
	assign q2_sum   = q0_q + mul_p_q[DW-1:0];

	always_comb begin
		stat.div_done = div_done;
		stat.mul_done = mul_done;
		stat.gb_zero  = gb_q == '0;
		stat.d_zero   = d_q == '0;
		stat.q1_zero  = q1_q == '0;
		stat.exact    = d0_q <= lim_q;
		stat.a_over   = a_q > div_q_q;
		stat.q2_over  = q2_sum > lim_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxd_q      <= MAXD_RESET;
			div_run_q   <= 1'b0;
			div_cnt_q   <= '0;
			mul_run_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				maxd_q <= cfg_wdata;
			end
			if (div_start) begin
				div_run_q <= 1'b1;
				div_cnt_q <= CNT_W'(DW);
			end else if (div_done) begin
				div_run_q <= 1'b0;
			end else if (div_run_q) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (mul_start) begin
				mul_run_q <= 1'b1;
			end else if (mul_done) begin
				mul_run_q <= 1'b0;
			end
			if (cmd == C_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// unit data paths
	always_ff @(posedge clk) begin
		if (div_start) begin
			div_r_q <= '0;
			div_q_q <= div_na;
			div_d_q <= div_nb;
		end else if (div_run_q && div_cnt_q != '0) begin
			div_r_q <= div_ge ? div_sub[DW-1:0] : div_sh[DW-1:0];
			div_q_q <= {div_q_q[DW-2:0], div_ge};
		end
		if (mul_start) begin
			mul_a_q <= mul_na;
			mul_b_q <= mul_nb;
			mul_p_q <= '0;
		end else if (mul_run_q && mul_b_q != '0) begin
			if (mul_b_q[0]) begin
				mul_p_q <= mul_p_q + mul_a_q;
			end
			mul_a_q <= {mul_a_q[PW-2:0], 1'b0};
			mul_b_q <= {1'b0, mul_b_q[DW-1:1]};
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd)
			C_LOAD: begin
				n0_q  <= DW'(in_data.value_magnitude);
				ga_q  <= DW'(in_data.value_magnitude);
				gb_q  <= SCALE;
				neg_q <= in_data.negative;
				lim_q <= (maxd_q == '0) ? DW'(1) : DW'(maxd_q);
			end
			C_GCD_UPD: begin
				ga_q <= gb_q;
				gb_q <= div_r_q;
			end
			C_RED1_UPD: n0_q <= div_q_q;
			C_RED2_UPD: d0_q <= div_q_q;
			C_EXACT: begin
				res_n_q <= n0_q;
				res_d_q <= d0_q;
			end
			C_CF_INIT: begin
				p0_q <= '0;
				q0_q <= DW'(1);
				p1_q <= DW'(1);
				q1_q <= '0;
				n_q  <= n0_q;
				d_q  <= d0_q;
			end
			C_CF_AUPD: begin
				a_q <= div_q_q;
				r_q <= div_r_q;
			end
			C_M1_UPD: q2_q <= q2_sum;
			C_M2_UPD: begin
				p1_q <= p0_q + mul_p_q[DW-1:0];
				p0_q <= p1_q;
				q0_q <= q1_q;
				q1_q <= q2_q;
				n_q  <= d_q;
				d_q  <= r_q;
			end
			C_K_FIX: begin
				if (q1_q == '0) begin
					q1_q <= DW'(1);
				end
			end
			C_K_UPD:  k_q  <= div_q_q;
			C_BN_UPD: bn_q <= p0_q + mul_p_q[DW-1:0];
			C_BD_UPD: bd_q <= q0_q + mul_p_q[DW-1:0];
			C_X_UPD:  x_q  <= mul_p_q;
			C_G_UPD:  g_q  <= (x_q >= mul_p_q) ? x_q - mul_p_q : mul_p_q - x_q;
			C_C1_UPD: c1_q <= mul_p_q;
			C_PICK: begin
				// tie goes to the convergent
				if (c1_q <= mul_p_q) begin
					res_n_q <= p1_q;
					res_d_q <= q1_q;
				end else begin
					res_n_q <= bn_q;
					res_d_q <= bd_q;
				end
			end
			C_OUT: begin
				out_q.result_negative <= neg_q;
				out_q.numerator       <= res_n_q[VALUE_WIDTH-1:0];
				out_q.denominator     <= res_d_q[DEN_WIDTH-1:0];
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.denominator != '0)
		else $error("zero denominator on output");
	a_div_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (!div_run_q || div_done))
		else $error("divider restarted while busy");
	a_mul_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> (!mul_run_q || mul_done))
		else $error("multiplier restarted while busy");

endmodule

// ===== design/bra_controller.sv =====
// Sequencer that steps the datapath through GCD reduction, convergents and final choice.
module bra_controller import bra_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bra_stat_t stat,
	output bra_cmd_t  cmd
);

	localparam logic [5:0] S_IDLE    = 6'd0;
	localparam logic [5:0] S_GCD_CHK = 6'd1;
	localparam logic [5:0] S_GCD_W   = 6'd2;
	localparam logic [5:0] S_RED1_W  = 6'd3;
	localparam logic [5:0] S_RED2    = 6'd4;
	localparam logic [5:0] S_RED2_W  = 6'd5;
	localparam logic [5:0] S_TEST    = 6'd6;
	localparam logic [5:0] S_CF_CHK  = 6'd7;
	localparam logic [5:0] S_CF_W    = 6'd8;
	localparam logic [5:0] S_CF_T    = 6'd9;
	localparam logic [5:0] S_T_W     = 6'd10;
	localparam logic [5:0] S_M1_W    = 6'd11;
	localparam logic [5:0] S_M2      = 6'd12;
	localparam logic [5:0] S_M2_W    = 6'd13;
	localparam logic [5:0] S_KFIX    = 6'd14;
	localparam logic [5:0] S_KDIV    = 6'd15;
	localparam logic [5:0] S_K_W     = 6'd16;
	localparam logic [5:0] S_BN      = 6'd17;
	localparam logic [5:0] S_BN_W    = 6'd18;
	localparam logic [5:0] S_BD      = 6'd19;
	localparam logic [5:0] S_BD_W    = 6'd20;
	localparam logic [5:0] S_X1      = 6'd21;
	localparam logic [5:0] S_X1_W    = 6'd22;
	localparam logic [5:0] S_Y1      = 6'd23;
	localparam logic [5:0] S_Y1_W    = 6'd24;
	localparam logic [5:0] S_C1      = 6'd25;
	localparam logic [5:0] S_C1_W    = 6'd26;
	localparam logic [5:0] S_X2      = 6'd27;
	localparam logic [5:0] S_X2_W    = 6'd28;
	localparam logic [5:0] S_Y2      = 6'd29;
	localparam logic [5:0] S_Y2_W    = 6'd30;
	localparam logic [5:0] S_C2      = 6'd31;
	localparam logic [5:0] S_C2_W    = 6'd32;
	localparam logic [5:0] S_DONE    = 6'd33;

	logic [5:0] state_q, state_nx;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_nx = state_q;
		cmd      = C_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd      = C_LOAD;
					state_nx = S_GCD_CHK;
				end
			end
			S_GCD_CHK: begin
				if (stat.gb_zero) begin
					cmd      = C_RED1_DIV;
					state_nx = S_RED1_W;
				end else begin
					cmd      = C_GCD_DIV;
					state_nx = S_GCD_W;
				end
			end
			S_GCD_W: begin
				if (stat.div_done) begin
					cmd      = C_GCD_UPD;
					state_nx = S_GCD_CHK;
				end
			end
			S_RED1_W: begin
				if (stat.div_done) begin
					cmd      = C_RED1_UPD;
					state_nx = S_RED2;
				end
			end
			S_RED2: begin
				cmd      = C_RED2_DIV;
				state_nx = S_RED2_W;
			end
			S_RED2_W: begin
				if (stat.div_done) begin
					cmd      = C_RED2_UPD;
					state_nx = S_TEST;
				end
			end
			S_TEST: begin
				if (stat.exact) begin
					cmd      = C_EXACT;
					state_nx = S_DONE;
				end else begin
					cmd      = C_CF_INIT;
					state_nx = S_CF_CHK;
				end
			end
			S_CF_CHK: begin
				if (stat.d_zero) begin
					state_nx = S_KFIX;
				end else begin
					cmd      = C_CF_DIV;
					state_nx = S_CF_W;
				end
			end
			S_CF_W: begin
				if (stat.div_done) begin
					cmd      = C_CF_AUPD;
					state_nx = S_CF_T;
				end
			end
			S_CF_T: begin
				if (stat.q1_zero) begin
					cmd      = C_M1_MUL;
					state_nx = S_M1_W;
				end else begin
					cmd      = C_T_DIV;
					state_nx = S_T_W;
				end
			end
			S_T_W: begin
				// drop out when the partial quotient would push past the limit
				if (stat.div_done) begin
					if (stat.a_over) begin
						state_nx = S_KFIX;
					end else begin
						cmd      = C_M1_MUL;
						state_nx = S_M1_W;
					end
				end
			end
			S_M1_W: begin
				if (stat.mul_done) begin
					if (stat.q2_over) begin
						state_nx = S_KFIX;
					end else begin
						cmd      = C_M1_UPD;
						state_nx = S_M2;
					end
				end
			end
			S_M2: begin
				cmd      = C_M2_MUL;
				state_nx = S_M2_W;
			end
			S_M2_W: begin
				if (stat.mul_done) begin
					cmd      = C_M2_UPD;
					state_nx = S_CF_CHK;
				end
			end
			S_KFIX: begin
				cmd      = C_K_FIX;
				state_nx = S_KDIV;
			end
			S_KDIV: begin
				cmd      = C_K_DIV;
				state_nx = S_K_W;
			end
			S_K_W: begin
				if (stat.div_done) begin
					cmd      = C_K_UPD;
					state_nx = S_BN;
				end
			end
			S_BN: begin
				cmd      = C_BN_MUL;
				state_nx = S_BN_W;
			end
			S_BN_W: begin
				if (stat.mul_done) begin
					cmd      = C_BN_UPD;
					state_nx = S_BD;
				end
			end
			S_BD: begin
				cmd      = C_BD_MUL;
				state_nx = S_BD_W;
			end
			S_BD_W: begin
				if (stat.mul_done) begin
					cmd      = C_BD_UPD;
					state_nx = S_X1;
				end
			end
			S_X1: begin
				cmd      = C_X1_MUL;
				state_nx = S_X1_W;
			end
			S_X1_W: begin
				if (stat.mul_done) begin
					cmd      = C_X_UPD;
					state_nx = S_Y1;
				end
			end
			S_Y1: begin
				cmd      = C_Y1_MUL;
				state_nx = S_Y1_W;
			end
			S_Y1_W: begin
				if (stat.mul_done) begin
					cmd      = C_G_UPD;
					state_nx = S_C1;
				end
			end
			S_C1: begin
				cmd      = C_C1_MUL;
				state_nx = S_C1_W;
			end
			S_C1_W: begin
				if (stat.mul_done) begin
					cmd      = C_C1_UPD;
					state_nx = S_X2;
				end
			end
			S_X2: begin
				cmd      = C_X2_MUL;
				state_nx = S_X2_W;
			end
			S_X2_W: begin
				if (stat.mul_done) begin
					cmd      = C_X_UPD;
					state_nx = S_Y2;
				end
			end
			S_Y2: begin
				cmd      = C_Y2_MUL;
				state_nx = S_Y2_W;
			end
			S_Y2_W: begin
				if (stat.mul_done) begin
					cmd      = C_G_UPD;
					state_nx = S_C2;
				end
			end
			S_C2: begin
				cmd      = C_C2_MUL;
				state_nx = S_C2_W;
			end
			S_C2_W: begin
				if (stat.mul_done) begin
					cmd      = C_PICK;
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd      = C_OUT;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == C_LOAD) |-> (in_ready && in_valid))
		else $error("load outside an accepted item");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == C_OUT) |-> stat.out_free)
		else $error("result loaded over a waiting item");
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && in_valid) |=> (state_q == S_GCD_CHK))
		else $error("accepted item did not start");

endmodule

// ===== design/best_rational_approximation.sv =====
// Top level: best rational approximation of a scaled value under a denominator limit.
// An exact value, whose reduced denominator is within the limit, skips the convergent steps and final choice.
// One item at a time, on the shared 1-bit-per-cycle divider and shift-add multiplier (one
// multiplier bit per cycle); a new item is accepted only when the controller is idle.
// Reset: arst_n clears control state and sets the denominator limit to 1000000.
module best_rational_approximation import bra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bra_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bra_out_t             out_data,
	input  logic                 cfg_wen,
	input  logic [DEN_WIDTH-1:0] cfg_wdata
);

	bra_cmd_t  cmd;
	bra_stat_t stat;

	bra_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bra_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.stat      (stat)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the best rational approximation block: random and directed values, checked in order.
`timescale 1ns / 1ps

class approx_scoreboard;
	bra_pkg::bra_out_t pending_fractions[$];
	int mismatches;
	bit [31:0] den_limit;

	function new();
		mismatches = 0;
		den_limit = bra_pkg::MAXD_RESET;
	endfunction

	// Absolute cross-product distance |a*d - n*b|.
	function bit [127:0] cross_gap(bit [63:0] a, bit [63:0] b, bit [63:0] n, bit [63:0] d);
		bit [127:0] x;
		bit [127:0] y;
		x = 128'(a) * 128'(d);
		y = 128'(n) * 128'(b);
		return (x > y) ? x - y : y - x;
	endfunction

	function bra_pkg::bra_out_t approximate(bra_pkg::bra_in_t item);
		bra_pkg::bra_out_t res;
		bit [63:0] lim, n0, d0, g, ga, gb, gt, rn, rd;
		bit [63:0] p0, q0, p1, q1, n, d, a, q2, t, k, bn, bd;
		bit [127:0] lhs, rhs;
		lim = (den_limit == 0) ? 64'd1 : 64'(den_limit);
		n0 = 64'(item.value_magnitude);
		d0 = 64'd1000000000000;
		ga = n0;
		gb = d0;
		while (gb != 0) begin
			gt = ga % gb;
			ga = gb;
			gb = gt;
		end
		g = ga;
		n0 = n0 / g;
		d0 = d0 / g;
		if (d0 <= lim) begin
			rn = n0;
			rd = d0;
		end else begin
			p0 = 0; q0 = 1; p1 = 1; q1 = 0;
			n = n0; d = d0;
			while (d != 0) begin
				a = n / d;
				if (q1 != 0 && a > (lim - q0) / q1) break;
				q2 = q0 + a * q1;
				if (q2 > lim) break;
				t = p1; p1 = p0 + a * p1; p0 = t;
				q0 = q1; q1 = q2;
				t = d; d = n - a * d; n = t;
			end
			if (q1 == 0) q1 = 1;
			k = (lim - q0) / q1;
			bn = p0 + k * p1;
			bd = q0 + k * q1;
			lhs = cross_gap(p1, q1, n0, d0) * 128'(bd);
			rhs = cross_gap(bn, bd, n0, d0) * 128'(q1);
			if (lhs <= rhs) begin
				rn = p1;
				rd = q1;
			end else begin
				rn = bn;
				rd = bd;
			end
		end
		res.result_negative = item.negative;
		res.numerator = rn[49:0];
		res.denominator = rd[31:0];
		return res;
	endfunction

	function void note_input(bra_pkg::bra_in_t item);
		pending_fractions.insert(pending_fractions.size(), approximate(item));
	endfunction

	function void check_result(bra_pkg::bra_out_t got);
		bra_pkg::bra_out_t want;
		if (pending_fractions.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %0d/%0d neg=%0b", got.numerator,
					got.denominator, got.result_negative);
			return;
		end
		want = pending_fractions.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected neg=%0b %0d/%0d, got neg=%0b %0d/%0d",
					want.result_negative, want.numerator, want.denominator,
					got.result_negative, got.numerator, got.denominator);
		end
	endfunction
endclass

module testbench;
	import bra_pkg::*;

	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	bra_in_t in_data;
	logic out_valid;
	logic out_ready;
	bra_out_t out_data;
	logic cfg_wen;
	logic [DEN_WIDTH-1:0] cfg_wdata;

	approx_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;
	bit timed_out;

	best_rational_approximation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Record accepted inputs, accept results and check them, and randomize back-pressure.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (in_valid && in_ready)
				sb.note_input(in_data);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Valid stays high after an accepted item unless the sender idles next.
	task automatic send_value(bit neg, bit [49:0] mag);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{negative: neg, value_magnitude: mag};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_fractions.size() != 0)
			@(posedge clk);
		repeat (5000) @(posedge clk);
	endtask

	task automatic set_limit(bit [31:0] lim);
		cfg_wen <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.den_limit = lim;
	endtask

	function automatic bit [49:0] random_value();
		bit [49:0] v;
		v = 50'({$urandom, $urandom});
		case ($urandom_range(5))
			0: v = v >> $urandom_range(49);
			1: v = 50'($urandom_range(1000)) * 50'd1000000000;
			2: v = 50'($urandom_range(1000000)) * 50'($urandom_range(1000000));
			3: v = 50'($urandom_range(50000));
			default: ;
		endcase
		return v;
	endfunction

	task automatic random_phase(int count);
		repeat (count)
			send_value(1'($urandom_range(1)), random_value());
	endtask

	initial begin
		sb = new();
		timed_out = 0;
		quiet_cycles = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_wen = 0;
		cfg_wdata = '0;
		send_idle_pct = 38;
		recv_idle_pct = 79;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: default limit, extremes, exact values, ties near halves.
		send_value(0, 0);
		send_value(1, 0);
		send_value(0, '1);
		send_value(1, '1);
		send_value(0, 50'd1000000000000);
		send_value(1, 50'd3141592653589);
		send_value(0, 50'd500000000000);
		send_value(0, 50'd333333333333);
		send_value(1, 50'd1);
		send_value(0, 50'd999999999999);
		send_value(0, 50'h2AAAAAAAAAAAA);
		send_value(1, 50'h1555555555555);
		drain();

		// Zero limit behaves as one: integers only, ties toward the convergent.
		set_limit(0);
		send_value(0, 50'd500000000000);
		send_value(1, 50'd1500000000000);
		send_value(0, 50'd2718281828459);
		drain();
		set_limit(1);
		send_value(0, 50'd2500000000000);
		send_value(0, 50'd1414213562373);
		drain();
		set_limit('1);
		send_value(0, 50'd3141592653589);
		send_value(1, 50'd1);
		send_value(0, '1);
		drain();
		set_limit(2);
		send_value(0, 50'd250000000000);
		send_value(0, 50'd750000000000);
		drain();

		set_limit(7);
		random_phase(300);
		drain();
		set_limit($urandom);
		random_phase(300);
		drain();

		send_idle_pct = 79;
		recv_idle_pct = 38;
		set_limit(1000);
		random_phase(300);
		drain();
		set_limit($urandom_range(100000));
		random_phase(300);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limit('1);
		random_phase(300);
		drain();
		set_limit(32'd1000000);
		random_phase(300);
		drain();

		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/bra_pkg.sv
design/bra_datapath.sv
design/bra_controller.sv
design/best_rational_approximation.sv
tb/sv/testbench.sv
